// ===== hw/rtl/gnct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_pkg
// Shared constants, codes and types of the gate crossing tracker.
// ----------------------------------------------------------------------------
package gnct_pkg;

   localparam int MAX_BLOBS_DEF  = 64;
   localparam int COORD_BITS_DEF = 12;

   localparam int GATE_W   = 13;
   localparam int DIST_W   = 9;
   localparam int LIMIT_W  = 2 * DIST_W;
   localparam int SLOT_W   = 6;
   localparam int FCNT_W   = 7;
   localparam int WIDE_W   = 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(320);
   localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(60);

   localparam logic CSR_GATE_POSITION      = 1'b0;
   localparam logic CSR_MAX_MATCH_DISTANCE = 1'b1;

   localparam logic REQ_CENTROID = 1'b0;
   localparam logic REQ_EOF      = 1'b1;

   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic list_full;
      logic prev_empty;
      logic scan_last;
      logic pipe_busy;
      logic out_free;
   } ctrl_status_type;

   typedef struct packed {
      logic              result_kind;
      logic              was_matched;
      logic [SLOT_W-1:0] match_slot;
      logic              gate_crossed;
      logic              capacity_overflow;
      logic [WIDE_W-1:0] frame_number;
      logic [WIDE_W-1:0] crossing_total;
      logic [FCNT_W-1:0] frame_crossings;
      logic [FCNT_W-1:0] frame_matches;
      logic [FCNT_W-1:0] previous_count;
      logic [FCNT_W-1:0] current_count;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/gnct_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_req_if
// Input channel: one centroid or an end-of-frame marker per item.
// ----------------------------------------------------------------------------
interface gnct_req_if #(
   parameter int COORD_BITS = gnct_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;

   modport source (output valid, output req_type, output pos_x, output pos_y, input ready);
   modport sink   (input valid, input req_type, input pos_x, input pos_y, output ready);
endinterface

// ===== hw/rtl/gnct_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_rsp_if
// Result channel: a per-centroid match result or a frame summary.
// ----------------------------------------------------------------------------
interface gnct_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic        was_matched;
   logic [5:0]  match_slot;
   logic        gate_crossed;
   logic        capacity_overflow;
   logic [31:0] frame_number;
   logic [31:0] crossing_total;
   logic [6:0]  frame_crossings;
   logic [6:0]  frame_matches;
   logic [6:0]  previous_count;
   logic [6:0]  current_count;

   modport source (
      output valid, input ready,
      output result_kind, output was_matched, output match_slot, output gate_crossed,
      output capacity_overflow, output frame_number, output crossing_total,
      output frame_crossings, output frame_matches, output previous_count,
      output current_count
   );
   modport sink (
      input valid, output ready,
      input result_kind, input was_matched, input match_slot, input gate_crossed,
      input capacity_overflow, input frame_number, input crossing_total,
      input frame_crossings, input frame_matches, input previous_count,
      input current_count
   );
endinterface

// ===== hw/rtl/gnct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gnct_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/gnct_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_csr
// Register bank for the gate position and the largest match distance.
// ----------------------------------------------------------------------------
module gnct_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gnct_pkg::CSR_AW-1:0] paddr,
   input  logic [gnct_pkg::CSR_DW-1:0] pwdata,
   output logic [gnct_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output logic [gnct_pkg::GATE_W-1:0] gate_position,
   output logic [gnct_pkg::DIST_W-1:0] max_match_distance
);
   import gnct_pkg::*;

   logic [GATE_W-1:0] gate_ff, gate_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              wr_hit;
   logic              reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_hit  = psel & penable & pwrite;

   always_comb begin
      gate_in = gate_ff;
      dist_in = dist_ff;
      if (wr_hit) begin
         unique case (reg_sel)
            CSR_GATE_POSITION:      gate_in = pwdata[GATE_W-1:0];
            CSR_MAX_MATCH_DISTANCE: dist_in = pwdata[DIST_W-1:0];
            default:                gate_in = gate_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_GATE_POSITION:      prdata = CSR_DW'(gate_ff);
         CSR_MAX_MATCH_DISTANCE: prdata = CSR_DW'(dist_ff);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= GATE_RESET;
         dist_ff <= DIST_RESET;
      end else begin
         gate_ff <= gate_in;
         dist_ff <= dist_in;
      end
   end

   assign gate_position      = gate_ff;
   assign max_match_distance = dist_ff;
endmodule

// ===== hw/rtl/gnct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_ctrl
// Sequencer: accepts an item, steps the scan of the previous list, waits
// for the distance pipeline to drain and hands the result to the output.
// ----------------------------------------------------------------------------
module gnct_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_type,
   output logic                      req_ready,
   input  gnct_pkg::ctrl_status_type status,
   output gnct_pkg::ctrl_cmd_type    cmd
);
   import gnct_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (req_type == REQ_EOF || status.list_full || status.prev_empty) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/gnct_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnct_datapath
// Centroid banks, taken marks, three-stage distance pipeline, best-match
// tracking, frame counters and the result register.
// ----------------------------------------------------------------------------
module gnct_datapath #(
   parameter int MAX_BLOBS  = gnct_pkg::MAX_BLOBS_DEF,
   parameter int COORD_BITS = gnct_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gnct_pkg::ctrl_cmd_type          cmd,
   output gnct_pkg::ctrl_status_type       status,
   input  logic                            req_type,
   input  logic [COORD_BITS-1:0]           pos_x,
   input  logic [COORD_BITS-1:0]           pos_y,
   input  logic [gnct_pkg::GATE_W-1:0]     gate_position,
   input  logic [gnct_pkg::DIST_W-1:0]     max_match_distance,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output gnct_pkg::rsp_payload_type       rsp_data
);
   import gnct_pkg::*;

   localparam int IDX_W      = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
   localparam int CNT_W      = $clog2(MAX_BLOBS + 1);
   localparam int BANK_DEPTH = 1 << IDX_W;
   localparam int ENTRY_W    = 2 * COORD_BITS;
   localparam int SUM_W      = 2 * COORD_BITS + 1;
   localparam int D2_W       = (SUM_W > 32) ? 32 : SUM_W;
   localparam int CMP_W      = (D2_W > LIMIT_W) ? D2_W : LIMIT_W;
   localparam int XW         = (GATE_W > COORD_BITS) ? GATE_W : COORD_BITS;

   // frame state
   logic                  bank_ff, bank_in;
   logic [CNT_W-1:0]      prev_count_ff, prev_count_in;
   logic [CNT_W-1:0]      cur_count_ff, cur_count_in;
   logic [BANK_DEPTH-1:0] taken_ff, taken_in;
   logic [FCNT_W-1:0]     fcross_ff, fcross_in;
   logic [FCNT_W-1:0]     fmatch_ff, fmatch_in;
   logic [WIDE_W-1:0]     frame_ctr_ff, frame_ctr_in;
   logic [WIDE_W-1:0]     total_ff, total_in;

   // item in progress
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic                  eof_ff, eof_in;
   logic                  ovf_ff, ovf_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;

   // pipeline
   logic                  s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic                  s1_taken_ff, s1_taken_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic [D2_W-1:0]       s2_d2_ff, s2_d2_in;
   logic [IDX_W-1:0]      s2_idx_ff;
   logic [COORD_BITS-1:0] s2_px_ff, s2_px_in;

   // best candidate
   logic [CMP_W-1:0]      best_d2_ff, best_d2_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [COORD_BITS-1:0] best_px_ff, best_px_in;
   logic                  found_ff, found_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // memory and arithmetic
   logic                  ram_wr_en;
   logic [IDX_W:0]        ram_wr_addr;
   logic [IDX_W:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [COORD_BITS-1:0] rd_px, rd_py;
   logic [COORD_BITS-1:0] dx, dy;
   logic [ENTRY_W-1:0]    dx_sq, dy_sq;
   logic [SUM_W-1:0]      d2_sum;
   logic [LIMIT_W-1:0]    limit;
   logic                  crossed;
   logic [WIDE_W-1:0]     new_total;

   gnct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (2 * BANK_DEPTH)
   ) u_banks (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({pos_x, pos_y}),
      .rd_en   (cmd.scan_step),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en   = cmd.start & (req_type == REQ_CENTROID) & ~status.list_full;
   assign ram_wr_addr = {bank_ff, cur_count_ff[IDX_W-1:0]};
   assign ram_rd_addr = {~bank_ff, scan_idx_ff};

   assign rd_px  = ram_rd_data[ENTRY_W-1:COORD_BITS];
   assign rd_py  = ram_rd_data[COORD_BITS-1:0];
   assign dx     = (cur_x_ff >= rd_px) ? cur_x_ff - rd_px : rd_px - cur_x_ff;
   assign dy     = (cur_y_ff >= rd_py) ? cur_y_ff - rd_py : rd_py - cur_y_ff;
   assign dx_sq  = dx * dx;
   assign dy_sq  = dy * dy;
   assign d2_sum = SUM_W'(dx_sq) + SUM_W'(dy_sq);
   assign limit  = max_match_distance * max_match_distance;

   assign crossed = found_ff
                  & (XW'(best_px_ff) < XW'(gate_position))
                  & (XW'(cur_x_ff) >= XW'(gate_position));
   assign new_total = total_ff + WIDE_W'(fcross_ff);

   assign status.list_full  = (cur_count_ff == CNT_W'(MAX_BLOBS));
   assign status.prev_empty = (prev_count_ff == '0);
   assign status.scan_last  = (CNT_W'(scan_idx_ff) == prev_count_ff - CNT_W'(1));
   assign status.pipe_busy  = s1_vld_ff | s2_vld_ff;
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      bank_in       = bank_ff;
      prev_count_in = prev_count_ff;
      cur_count_in  = cur_count_ff;
      taken_in      = taken_ff;
      fcross_in     = fcross_ff;
      fmatch_in     = fmatch_ff;
      frame_ctr_in  = frame_ctr_ff;
      total_in      = total_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      eof_in        = eof_ff;
      ovf_in        = ovf_ff;
      scan_idx_in   = scan_idx_ff;
      best_d2_in    = best_d2_ff;
      best_idx_in   = best_idx_ff;
      best_px_in    = best_px_ff;
      found_in      = found_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      // accept
      if (cmd.start) begin
         cur_x_in    = pos_x;
         cur_y_in    = pos_y;
         eof_in      = (req_type == REQ_EOF);
         ovf_in      = (req_type == REQ_CENTROID) & status.list_full;
         scan_idx_in = '0;
         best_d2_in  = CMP_W'(limit);
         best_idx_in = '0;
         best_px_in  = '0;
         found_in    = 1'b0;
         if (ram_wr_en) begin
            cur_count_in = cur_count_ff + CNT_W'(1);
         end
      end

      // scan issue
      s1_vld_in   = cmd.scan_step;
      s1_idx_in   = scan_idx_ff;
      s1_taken_in = taken_ff[scan_idx_ff];
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      // distance stage
      s2_vld_in = s1_vld_ff & ~s1_taken_ff;
      s2_d2_in  = D2_W'(d2_sum);
      s2_px_in  = rd_px;

      // compare stage, later index wins ties
      if (s2_vld_ff && (CMP_W'(s2_d2_ff) <= best_d2_ff)) begin
         best_d2_in  = CMP_W'(s2_d2_ff);
         best_idx_in = s2_idx_ff;
         best_px_in  = s2_px_ff;
         found_in    = 1'b1;
      end

      // result
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (eof_ff) begin
            rsp_data_in.result_kind     = KIND_SUMMARY;
            rsp_data_in.frame_number    = frame_ctr_ff;
            rsp_data_in.crossing_total  = new_total;
            rsp_data_in.frame_crossings = fcross_ff;
            rsp_data_in.frame_matches   = fmatch_ff;
            rsp_data_in.previous_count  = FCNT_W'(prev_count_ff);
            rsp_data_in.current_count   = FCNT_W'(cur_count_ff);
            total_in      = new_total;
            prev_count_in = cur_count_ff;
            cur_count_in  = '0;
            bank_in       = ~bank_ff;
            taken_in      = '0;
            fcross_in     = '0;
            fmatch_in     = '0;
            frame_ctr_in  = frame_ctr_ff + WIDE_W'(1);
         end else if (ovf_ff) begin
            rsp_data_in.result_kind       = KIND_MATCH;
            rsp_data_in.capacity_overflow = 1'b1;
         end else begin
            rsp_data_in.result_kind = KIND_MATCH;
            if (found_ff) begin
               rsp_data_in.was_matched  = 1'b1;
               rsp_data_in.match_slot   = SLOT_W'(best_idx_ff);
               rsp_data_in.gate_crossed = crossed;
               taken_in[best_idx_ff]    = 1'b1;
               fmatch_in                = fmatch_ff + FCNT_W'(1);
               if (crossed) begin
                  fcross_in = fcross_ff + FCNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff       <= 1'b0;
         prev_count_ff <= '0;
         cur_count_ff  <= '0;
         taken_ff      <= '0;
         fcross_ff     <= '0;
         fmatch_ff     <= '0;
         frame_ctr_ff  <= '0;
         total_ff      <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bank_ff       <= bank_in;
         prev_count_ff <= prev_count_in;
         cur_count_ff  <= cur_count_in;
         taken_ff      <= taken_in;
         fcross_ff     <= fcross_in;
         fmatch_ff     <= fmatch_in;
         frame_ctr_ff  <= frame_ctr_in;
         total_ff      <= total_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      eof_ff      <= eof_in;
      ovf_ff      <= ovf_in;
      scan_idx_ff <= scan_idx_in;
      s1_idx_ff   <= s1_idx_in;
      s1_taken_ff <= s1_taken_in;
      s2_d2_ff    <= s2_d2_in;
      s2_idx_ff   <= s1_idx_ff;
      s2_px_ff    <= s2_px_in;
      best_d2_ff  <= best_d2_in;
      best_idx_ff <= best_idx_in;
      best_px_ff  <= best_px_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== hw/rtl/greedy_nn_gate_crossing_tracker_core.sv =====
`timescale 1ns / 1ps
// a centroid is accepted, scans the previous list, waits for the distance pipeline to
// drain and is then loaded into the result register; end of frame, list-full and
// empty-previous-list items skip the scan; a stalled result register adds its stall
// one item at a time: no new item is accepted until the result of the last one is
// loaded into the result register, and the bank scan reads one entry per cycle
// reset: synchronous, clears lists, taken marks, counters and the result register
// ----------------------------------------------------------------------------
// greedy_nn_gate_crossing_tracker_core
// Greedy nearest-neighbour centroid tracker with a vertical counting gate.
// ----------------------------------------------------------------------------
module greedy_nn_gate_crossing_tracker_core #(
   parameter int MAX_BLOBS  = gnct_pkg::MAX_BLOBS_DEF,
   parameter int COORD_BITS = gnct_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   gnct_req_if.sink                    req_ch,
   gnct_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gnct_pkg::CSR_AW-1:0] paddr,
   input  logic [gnct_pkg::CSR_DW-1:0] pwdata,
   output logic [gnct_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import gnct_pkg::*;

   ctrl_cmd_type      cmd;
   ctrl_status_type   status;
   rsp_payload_type   rsp_data;
   logic              rsp_valid;
   logic [GATE_W-1:0] gate_position;
   logic [DIST_W-1:0] max_match_distance;

   gnct_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .gate_position      (gate_position),
      .max_match_distance (max_match_distance)
   );

   gnct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gnct_datapath #(
      .MAX_BLOBS  (MAX_BLOBS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_ch.req_type),
      .pos_x              (req_ch.pos_x),
      .pos_y              (req_ch.pos_y),
      .gate_position      (gate_position),
      .max_match_distance (max_match_distance),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_valid),
      .rsp_data           (rsp_data)
   );

   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.result_kind       = rsp_data.result_kind;
   assign rsp_ch.was_matched       = rsp_data.was_matched;
   assign rsp_ch.match_slot        = rsp_data.match_slot;
   assign rsp_ch.gate_crossed      = rsp_data.gate_crossed;
   assign rsp_ch.capacity_overflow = rsp_data.capacity_overflow;
   assign rsp_ch.frame_number      = rsp_data.frame_number;
   assign rsp_ch.crossing_total    = rsp_data.crossing_total;
   assign rsp_ch.frame_crossings   = rsp_data.frame_crossings;
   assign rsp_ch.frame_matches     = rsp_data.frame_matches;
   assign rsp_ch.previous_count    = rsp_data.previous_count;
   assign rsp_ch.current_count     = rsp_data.current_count;

`ifndef SYNTH
   a_emit_needs_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while output register still full");

   a_scan_needs_list : assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !status.prev_empty)
      else $error("scan issued against an empty previous list");

   a_idle_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !status.pipe_busy)
      else $error("new item accepted while distance pipeline busy");
`endif
endmodule
